### design/pif2d_pkg.sv
package pif2d_pkg;

  // word and port widths
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned PERIOD_US_DEF = 1000;

  // serial multiplier: signed A up to 34 bits, signed B up to 49 bits
  localparam int unsigned OPA_W     = 34;
  localparam int unsigned OPB_W     = 49;
  localparam int unsigned BMAG_W    = OPB_W - 1;
  localparam int unsigned DIG_W     = 4;
  localparam int unsigned ACC_W     = OPA_W + BMAG_W;
  localparam int unsigned MUL_STEPS = BMAG_W / DIG_W;
  localparam int unsigned DCNT_W    = 4;

  // serial divider
  localparam int unsigned QUO_W  = 32;
  localparam int unsigned QCNT_W = 5;

  // running sum of the right-hand side
  localparam int unsigned RACC_W = 36;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MASS_11 = 3'd0,
    CFG_MASS_12 = 3'd1,
    CFG_MASS_21 = 3'd2,
    CFG_MASS_22 = 3'd3,
    CFG_DAMP_11 = 3'd4,
    CFG_DAMP_12 = 3'd5,
    CFG_DAMP_21 = 3'd6,
    CFG_DAMP_22 = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] stiff_11;
    logic signed [DATA_W-1:0] stiff_12;
    logic signed [DATA_W-1:0] stiff_21;
    logic signed [DATA_W-1:0] stiff_22;
    logic signed [DATA_W-1:0] ref_pos_x;
    logic signed [DATA_W-1:0] ref_pos_y;
    logic signed [DATA_W-1:0] meas_force_x;
    logic signed [DATA_W-1:0] meas_force_y;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] cmd_pos_x;
    logic signed [DATA_W-1:0] cmd_pos_y;
    logic                     singular;
  } out_word_t;

  // saturate to the signed 32-bit range
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [39:0] v);
    logic signed [39:0] hi;
    logic signed [39:0] lo;
    hi = 40'sh00_7FFF_FFFF;
    lo = -40'sh00_8000_0000;
    if (v > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end
    return v[DATA_W-1:0];
  endfunction

endpackage

### design/pif2d_in_if.sv
interface pif2d_in_if
  import pif2d_pkg::*;
();
  logic     valid;
  logic     ready;
  in_word_t word;

  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

### design/pif2d_out_if.sv
interface pif2d_out_if
  import pif2d_pkg::*;
();
  logic      valid;
  logic      ready;
  out_word_t word;

  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

### design/position_impedance_filter_2d.sv
// Two-axis position-based impedance filter (bilinear form). One word carries
// the stiffness matrix, the reference position and the measured force; one
// word comes back with the commanded position and a singular flag. All 24
// products run through one shared shift-add multiplier that takes a 4-bit
// digit of its second operand per cycle, after a load step and before a
// rounding step, and both quotients through a restoring divider that
// makes one bit per cycle; the divider is skipped when w1 is singular and
// for an axis whose quotient saturates. A new word is taken once the
// previous one has reached the output register, even while that result
// still waits to be read.
module position_impedance_filter_2d
  import pif2d_pkg::*;
#(
  parameter int unsigned PERIOD_US = PERIOD_US_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_data_i,
  pif2d_in_if.sink             in_i,
  pif2d_out_if.source          out_o
);

  // period T in Q32 and T^2 in Q48
  localparam logic [63:0] T_Q32 =
    (64'(PERIOD_US) * 64'd4294967296 + 64'd500000) / 64'd1000000;
  localparam logic [63:0] T2_Q48 = (T_Q32 * T_Q32 + 64'd32768) >> 16;
  localparam logic signed [OPB_W-1:0] T_OPB  = $signed({1'b0, T_Q32[BMAG_W-1:0]});
  localparam logic signed [OPB_W-1:0] T2_OPB = $signed({1'b0, T2_Q48[BMAG_W-1:0]});

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_LOAD  = 9'b000000010,
    ST_MUL   = 9'b000000100,
    ST_POST  = 9'b000001000,
    ST_WCALC = 9'b000010000,
    ST_DCHK  = 9'b000100000,
    ST_DIV   = 9'b001000000,
    ST_DEND  = 9'b010000000,
    ST_FIN   = 9'b100000000
  } state_e;

  typedef enum logic [4:0] {
    OP_KT2_0 = 5'd0,  OP_KT2_1 = 5'd1,  OP_KT2_2 = 5'd2,  OP_KT2_3 = 5'd3,
    OP_DT_0  = 5'd4,  OP_DT_1  = 5'd5,  OP_DT_2  = 5'd6,  OP_DT_3  = 5'd7,
    OP_FT_X  = 5'd8,  OP_P1_X  = 5'd9,  OP_P2_X  = 5'd10, OP_Q1_X  = 5'd11,
    OP_Q2_X  = 5'd12, OP_FT_Y  = 5'd13, OP_P1_Y  = 5'd14, OP_P2_Y  = 5'd15,
    OP_Q1_Y  = 5'd16, OP_Q2_Y  = 5'd17, OP_DET_A = 5'd18, OP_DET_B = 5'd19,
    OP_NX_A  = 5'd20, OP_NX_B  = 5'd21, OP_NY_A  = 5'd22, OP_NY_B  = 5'd23
  } op_e;

  typedef enum logic [1:0] {
    MK_SH16  = 2'd0,
    MK_SH32  = 2'd1,
    MK_SH48  = 2'd2,
    MK_EXACT = 2'd3
  } mul_kind_e;

  state_e state_q;
  op_e    op_q;

  logic signed [DATA_W-1:0] mass_q  [4];
  logic signed [DATA_W-1:0] damp_q  [4];
  logic signed [DATA_W-1:0] stiff_q [4];
  logic signed [DATA_W-1:0] ref_h_q [3][2];
  logic signed [DATA_W-1:0] frc_h_q [3][2];
  logic signed [DATA_W-1:0] cmd_h_q [2][2];
  logic signed [DATA_W-1:0] kt2_q   [4];
  logic signed [DATA_W-1:0] dt_q    [4];
  logic signed [DATA_W-1:0] w1_q    [4];
  logic signed [DATA_W-1:0] w2_q    [4];
  logic signed [DATA_W-1:0] w3_q    [4];
  logic signed [DATA_W-1:0] r_q     [2];
  logic signed [DATA_W-1:0] res_q   [2];
  logic signed [RACC_W-1:0] racc_q;
  logic [63:0]              det_q, nx_q, ny_q;
  logic                     sing_q;

  // multiplier state
  logic [ACC_W-1:0]  acc_q;
  logic [OPA_W-1:0]  amag_q;
  logic              neg_q;
  logic [DCNT_W-1:0] dig_q;

  // divider state
  logic [63:0]       rem_q, ud_q;
  logic [QUO_W-1:0]  dlo_q, quo_q;
  logic [QCNT_W-1:0] qcnt_q;
  logic              ax_q, dneg_q, dovf_q;

  logic      out_valid_q;
  out_word_t out_word_q;

  // ---------------------------------------------------------------- operands
  logic signed [DATA_W-1:0] e1 [2];
  logic signed [DATA_W-1:0] e2 [2];
  logic signed [OPA_W-1:0]  fs [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      e1[i] = sat32(40'(ref_h_q[1][i]) - 40'(cmd_h_q[0][i]));
      e2[i] = sat32(40'(ref_h_q[2][i]) - 40'(cmd_h_q[1][i]));
      fs[i] = OPA_W'(frc_h_q[0][i]) + (OPA_W'(frc_h_q[1][i]) <<< 1)
            + OPA_W'(frc_h_q[2][i]);
    end
  end

  logic signed [OPA_W-1:0] opa;
  logic signed [OPB_W-1:0] opb;
  mul_kind_e               kind;

  // pick the operand pair and rounding mode of the current product
  always_comb begin
    opa  = '0;
    opb  = '0;
    kind = MK_EXACT;
    unique case (op_q)
      OP_KT2_0, OP_KT2_1, OP_KT2_2, OP_KT2_3: begin
        opa = OPA_W'(stiff_q[op_q[1:0]]); opb = T2_OPB; kind = MK_SH32;
      end
      OP_DT_0, OP_DT_1, OP_DT_2, OP_DT_3: begin
        opa = OPA_W'(damp_q[op_q[1:0]]); opb = T_OPB; kind = MK_SH32;
      end
      OP_FT_X:  begin opa = fs[0]; opb = T2_OPB; kind = MK_SH48; end
      OP_P1_X:  begin opa = OPA_W'(w2_q[0]); opb = OPB_W'(e1[0]); kind = MK_SH16; end
      OP_P2_X:  begin opa = OPA_W'(w2_q[1]); opb = OPB_W'(e1[1]); kind = MK_SH16; end
      OP_Q1_X:  begin opa = OPA_W'(w3_q[0]); opb = OPB_W'(e2[0]); kind = MK_SH16; end
      OP_Q2_X:  begin opa = OPA_W'(w3_q[1]); opb = OPB_W'(e2[1]); kind = MK_SH16; end
      OP_FT_Y:  begin opa = fs[1]; opb = T2_OPB; kind = MK_SH48; end
      OP_P1_Y:  begin opa = OPA_W'(w2_q[2]); opb = OPB_W'(e1[0]); kind = MK_SH16; end
      OP_P2_Y:  begin opa = OPA_W'(w2_q[3]); opb = OPB_W'(e1[1]); kind = MK_SH16; end
      OP_Q1_Y:  begin opa = OPA_W'(w3_q[2]); opb = OPB_W'(e2[0]); kind = MK_SH16; end
      OP_Q2_Y:  begin opa = OPA_W'(w3_q[3]); opb = OPB_W'(e2[1]); kind = MK_SH16; end
      OP_DET_A: begin opa = OPA_W'(w1_q[0]); opb = OPB_W'(w1_q[3]); end
      OP_DET_B: begin opa = OPA_W'(w1_q[1]); opb = OPB_W'(w1_q[2]); end
      OP_NX_A:  begin opa = OPA_W'(w1_q[3]); opb = OPB_W'(r_q[0]); end
      OP_NX_B:  begin opa = OPA_W'(w1_q[1]); opb = OPB_W'(r_q[1]); end
      OP_NY_A:  begin opa = OPA_W'(w1_q[0]); opb = OPB_W'(r_q[1]); end
      OP_NY_B:  begin opa = OPA_W'(w1_q[2]); opb = OPB_W'(r_q[0]); end
      default: ;
    endcase
  end

  logic [OPA_W-1:0] amag;
  logic [OPB_W-1:0] bmag;
  assign amag = opa[OPA_W-1] ? OPA_W'(-opa) : OPA_W'(opa);
  assign bmag = opb[OPB_W-1] ? OPB_W'(-opb) : OPB_W'(opb);

  // one digit step of the shift-add multiplier
  logic [OPA_W+DIG_W-1:0] dsum;
  assign dsum = (OPA_W+DIG_W)'(acc_q[ACC_W-1:BMAG_W])
              + (OPA_W+DIG_W)'(amag_q) * (OPA_W+DIG_W)'(acc_q[DIG_W-1:0]);

  // round, shift and saturate the finished product
  logic [ACC_W:0]            rsum, rsh;
  logic [DATA_W-1:0]         mmag;
  logic signed [DATA_W-1:0]  mres;
  logic [63:0]               p64;
  logic signed [RACC_W-1:0]  racc_sub;
  logic signed [DATA_W-1:0]  rnext;

  always_comb begin
    unique case (kind)
      MK_SH16: begin
        rsum = {1'b0, acc_q} + ((ACC_W+1)'(1) << 15);
        rsh  = rsum >> 16;
      end
      MK_SH32: begin
        rsum = {1'b0, acc_q} + ((ACC_W+1)'(1) << 31);
        rsh  = rsum >> 32;
      end
      MK_SH48: begin
        rsum = {1'b0, acc_q} + ((ACC_W+1)'(1) << 47);
        rsh  = rsum >> 48;
      end
      MK_EXACT: begin
        rsum = {1'b0, acc_q};
        rsh  = rsum;
      end
    endcase
    if ((|rsh[ACC_W:DATA_W]) || (rsh[DATA_W-1:0] > 32'h8000_0000)) begin
      mmag = 32'h8000_0000;
    end else begin
      mmag = rsh[DATA_W-1:0];
    end
    if (neg_q) begin
      mres = $signed(32'(33'd0 - {1'b0, mmag}));
    end else if (mmag[DATA_W-1]) begin
      mres = 32'sh7FFF_FFFF;
    end else begin
      mres = $signed(mmag);
    end
    p64      = neg_q ? (64'd0 - acc_q[63:0]) : acc_q[63:0];
    racc_sub = racc_q - RACC_W'(mres);
    rnext    = sat32(40'(racc_sub));
  end

  // bilinear weight matrices
  logic signed [DATA_W-1:0] w1_n [4];
  logic signed [DATA_W-1:0] w2_n [4];
  logic signed [DATA_W-1:0] w3_n [4];

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      w1_n[j] = sat32(40'(kt2_q[j]) + (40'(dt_q[j]) <<< 1) + (40'(mass_q[j]) <<< 2));
      w2_n[j] = sat32((40'(kt2_q[j]) <<< 1) - (40'(mass_q[j]) <<< 3));
      w3_n[j] = sat32(40'(kt2_q[j]) - (40'(dt_q[j]) <<< 1) + (40'(mass_q[j]) <<< 2));
    end
  end

  // divider setup, step and final scaling
  logic [63:0]             num, un, ud;
  logic                    dovf;
  logic [64:0]             dtry;
  logic                    dge;
  logic [QUO_W:0]          qm;
  logic signed [DATA_W-1:0] qd;
  logic signed [DATA_W-1:0] xc;

  always_comb begin
    num  = ax_q ? ny_q : nx_q;
    un   = num[63] ? (64'd0 - num) : num;
    ud   = det_q[63] ? (64'd0 - det_q) : det_q;
    dovf = {16'd0, un} >= {ud, 16'd0};
    dtry = {rem_q, dlo_q[QUO_W-1]};
    dge  = dtry >= {1'b0, ud_q};
    qm   = dovf_q ? {1'b1, QUO_W'(0)} : {1'b0, quo_q};
    if (dneg_q) begin
      qd = (qm > 33'h0_8000_0000) ? 32'sh8000_0000 : $signed(32'(33'd0 - qm));
    end else begin
      qd = (qm > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(qm[DATA_W-1:0]);
    end
    xc = sat32(40'(ref_h_q[0][ax_q]) - 40'(qd));
  end

  assign in_i.ready  = (state_q == ST_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.word  = out_word_q;

  // sequencer, datapath and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_KT2_0;
      mass_q      <= '{32'sd65536, 32'sd0, 32'sd0, 32'sd65536};
      damp_q      <= '{default: '0};
      stiff_q     <= '{default: '0};
      ref_h_q     <= '{default: '{default: '0}};
      frc_h_q     <= '{default: '{default: '0}};
      cmd_h_q     <= '{default: '{default: '0}};
      kt2_q       <= '{default: '0};
      dt_q        <= '{default: '0};
      w1_q        <= '{default: '0};
      w2_q        <= '{default: '0};
      w3_q        <= '{default: '0};
      r_q         <= '{default: '0};
      res_q       <= '{default: '0};
      racc_q      <= '0;
      det_q       <= '0;
      nx_q        <= '0;
      ny_q        <= '0;
      sing_q      <= 1'b0;
      acc_q       <= '0;
      amag_q      <= '0;
      neg_q       <= 1'b0;
      dig_q       <= '0;
      rem_q       <= '0;
      ud_q        <= '0;
      dlo_q       <= '0;
      quo_q       <= '0;
      qcnt_q      <= '0;
      ax_q        <= 1'b0;
      dneg_q      <= 1'b0;
      dovf_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
    end else begin
      // configuration writes
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_MASS_11: mass_q[0] <= $signed(cfg_data_i);
          CFG_MASS_12: mass_q[1] <= $signed(cfg_data_i);
          CFG_MASS_21: mass_q[2] <= $signed(cfg_data_i);
          CFG_MASS_22: mass_q[3] <= $signed(cfg_data_i);
          CFG_DAMP_11: damp_q[0] <= $signed(cfg_data_i);
          CFG_DAMP_12: damp_q[1] <= $signed(cfg_data_i);
          CFG_DAMP_21: damp_q[2] <= $signed(cfg_data_i);
          CFG_DAMP_22: damp_q[3] <= $signed(cfg_data_i);
        endcase
      end

      // drop the output word once taken, unless a new one replaces it
      if (out_valid_q && out_o.ready && (state_q != ST_FIN)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          // take a word and advance the reference and force lines
          if (in_i.valid) begin
            stiff_q    <= '{in_i.word.stiff_11, in_i.word.stiff_12,
                            in_i.word.stiff_21, in_i.word.stiff_22};
            ref_h_q[2] <= ref_h_q[1];
            ref_h_q[1] <= ref_h_q[0];
            ref_h_q[0] <= '{in_i.word.ref_pos_x, in_i.word.ref_pos_y};
            frc_h_q[2] <= frc_h_q[1];
            frc_h_q[1] <= frc_h_q[0];
            frc_h_q[0] <= '{in_i.word.meas_force_x, in_i.word.meas_force_y};
            op_q       <= OP_KT2_0;
            state_q    <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          amag_q  <= amag;
          neg_q   <= opa[OPA_W-1] ^ opb[OPB_W-1];
          acc_q   <= {OPA_W'(0), bmag[BMAG_W-1:0]};
          dig_q   <= '0;
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          acc_q <= {dsum, acc_q[BMAG_W-1:DIG_W]};
          dig_q <= dig_q + 1'b1;
          if (dig_q == DCNT_W'(MUL_STEPS - 1)) begin
            state_q <= ST_POST;
          end
        end
        ST_POST: begin
          unique case (op_q)
            OP_KT2_0, OP_KT2_1, OP_KT2_2, OP_KT2_3: kt2_q[op_q[1:0]] <= mres;
            OP_DT_0, OP_DT_1, OP_DT_2, OP_DT_3:     dt_q[op_q[1:0]]  <= mres;
            OP_FT_X, OP_FT_Y:                       racc_q <= RACC_W'(mres);
            OP_P1_X, OP_P2_X, OP_Q1_X,
            OP_P1_Y, OP_P2_Y, OP_Q1_Y:              racc_q <= racc_sub;
            OP_Q2_X:  r_q[0] <= rnext;
            OP_Q2_Y:  r_q[1] <= rnext;
            OP_DET_A: det_q  <= p64;
            OP_DET_B: det_q  <= det_q - p64;
            OP_NX_A:  nx_q   <= p64;
            OP_NX_B:  nx_q   <= nx_q - p64;
            OP_NY_A:  ny_q   <= p64;
            OP_NY_B:  ny_q   <= ny_q - p64;
            default: ;
          endcase
          if (op_q == OP_DT_3) begin
            state_q <= ST_WCALC;
          end else if (op_q == OP_NY_B) begin
            ax_q    <= 1'b0;
            state_q <= ST_DCHK;
          end else begin
            op_q    <= op_e'(op_q + 5'd1);
            state_q <= ST_LOAD;
          end
        end
        ST_WCALC: begin
          w1_q    <= w1_n;
          w2_q    <= w2_n;
          w3_q    <= w3_n;
          op_q    <= OP_FT_X;
          state_q <= ST_LOAD;
        end
        ST_DCHK: begin
          // singular w1: hold the output at the reference
          if (det_q == 64'd0) begin
            sing_q  <= 1'b1;
            res_q   <= ref_h_q[0];
            state_q <= ST_FIN;
          end else begin
            sing_q  <= 1'b0;
            dneg_q  <= num[63] ^ det_q[63];
            dovf_q  <= dovf;
            ud_q    <= ud;
            rem_q   <= {16'd0, un[63:16]};
            dlo_q   <= {un[15:0], 16'd0};
            quo_q   <= '0;
            qcnt_q  <= '0;
            state_q <= dovf ? ST_DEND : ST_DIV;
          end
        end
        ST_DIV: begin
          rem_q  <= dge ? 64'(dtry - {1'b0, ud_q}) : dtry[63:0];
          quo_q  <= {quo_q[QUO_W-2:0], dge};
          dlo_q  <= {dlo_q[QUO_W-2:0], 1'b0};
          qcnt_q <= qcnt_q + 1'b1;
          if (qcnt_q == QCNT_W'(QUO_W - 1)) begin
            state_q <= ST_DEND;
          end
        end
        ST_DEND: begin
          res_q[ax_q] <= xc;
          if (ax_q) begin
            state_q <= ST_FIN;
          end else begin
            ax_q    <= 1'b1;
            state_q <= ST_DCHK;
          end
        end
        ST_FIN: begin
          // hand over once the output register is free
          if (!out_valid_q || out_o.ready) begin
            out_valid_q          <= 1'b1;
            out_word_q.cmd_pos_x <= res_q[0];
            out_word_q.cmd_pos_y <= res_q[1];
            out_word_q.singular  <= sing_q;
            cmd_h_q[1]           <= cmd_h_q[0];
            cmd_h_q[0]           <= res_q;
            state_q              <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

### test/position_impedance_filter_2d_tb.sv
module position_impedance_filter_2d_tb;
  import pif2d_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // latency of one word plus margin
  localparam int unsigned DRAIN_CYCLES = 450;
  localparam longint T_Q32 = (64'(PERIOD_US_DEF) * 64'h1_0000_0000 + 500000) / 1000000;
  localparam longint T2_Q48 = (T_Q32 * T_Q32 + 32768) >>> 16;
  localparam longint S32_MAX = 64'sh7FFF_FFFF;
  localparam longint S32_MIN = -64'sh8000_0000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [DATA_W-1:0] cfg_data;

  pif2d_in_if in_if ();
  pif2d_out_if out_if ();

  position_impedance_filter_2d u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // filter state mirrored by the testbench
  longint mass_q [2][2];
  longint damp_q [2][2];
  longint ref_hist [3][2];
  longint cmd_hist [3][2];
  longint force_hist [3][2];

  out_word_t cmd_expected_q [$];
  int unsigned err_cnt;
  bit idle_en;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic longint sat_word(longint v);
    if (v > S32_MAX) begin
      return S32_MAX;
    end else if (v < S32_MIN) begin
      return S32_MIN;
    end
    return v;
  endfunction

  function automatic logic signed [127:0] widen(longint v);
    logic signed [127:0] r;
    r = v;
    return r;
  endfunction

  function automatic logic [127:0] magnitude(logic signed [127:0] v);
    return (v < 0) ? -v : v;
  endfunction

  // exact product, rounded half away from zero, shifted and saturated
  function automatic longint mul_round(longint a, longint b, int s);
    logic [127:0] p;
    bit neg;
    neg = (a < 0) != (b < 0);
    p = magnitude(widen(a)) * magnitude(widen(b));
    p = (p + (128'd1 << (s - 1))) >> s;
    if (p > 128'h8000_0000) p = 128'h8000_0000;
    return sat_word(neg ? -longint'(p[63:0]) : longint'(p[63:0]));
  endfunction

  // num * 2^16 / den, truncated toward zero, saturated
  function automatic longint quot_q16(logic signed [127:0] num, logic signed [127:0] den);
    logic [127:0] m;
    bit neg;
    neg = (num < 0) != (den < 0);
    m = (magnitude(num) << 16) / magnitude(den);
    if (m > 128'h1_0000_0000) m = 128'h1_0000_0000;
    return sat_word(neg ? -longint'(m[63:0]) : longint'(m[63:0]));
  endfunction

  function automatic void clear_filter();
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 2; j++) begin
        ref_hist[i][j] = 0;
        cmd_hist[i][j] = 0;
        force_hist[i][j] = 0;
      end
    end
    mass_q = '{'{65536, 0}, '{0, 65536}};
    damp_q = '{'{0, 0}, '{0, 0}};
  endfunction

  // advance the mirrored filter by one word and return the commanded position
  function automatic out_word_t impedance_step(in_word_t w);
    longint stiff [2][2];
    longint w1 [2][2];
    longint w2 [2][2];
    longint w3 [2][2];
    longint e1 [2];
    longint e2 [2];
    longint rhs [2];
    longint xc [2];
    longint kt2, dt, fs, ft, p, q;
    logic signed [127:0] det, nx, ny;
    out_word_t r;
    stiff = '{'{longint'(w.stiff_11), longint'(w.stiff_12)},
              '{longint'(w.stiff_21), longint'(w.stiff_22)}};
    for (int i = 2; i > 0; i--) begin
      ref_hist[i] = ref_hist[i-1];
      force_hist[i] = force_hist[i-1];
    end
    ref_hist[0] = '{longint'(w.ref_pos_x), longint'(w.ref_pos_y)};
    force_hist[0] = '{longint'(w.meas_force_x), longint'(w.meas_force_y)};
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        kt2 = mul_round(stiff[i][j], T2_Q48, 32);
        dt = mul_round(damp_q[i][j], T_Q32, 32);
        w1[i][j] = sat_word(kt2 + 2 * dt + 4 * mass_q[i][j]);
        w2[i][j] = sat_word(2 * kt2 - 8 * mass_q[i][j]);
        w3[i][j] = sat_word(kt2 - 2 * dt + 4 * mass_q[i][j]);
      end
    end
    for (int i = 0; i < 2; i++) begin
      e1[i] = sat_word(ref_hist[1][i] - cmd_hist[0][i]);
      e2[i] = sat_word(ref_hist[2][i] - cmd_hist[1][i]);
    end
    for (int i = 0; i < 2; i++) begin
      fs = force_hist[0][i] + 2 * force_hist[1][i] + force_hist[2][i];
      ft = mul_round(fs, T2_Q48, 48);
      p = mul_round(w2[i][0], e1[0], 16) + mul_round(w2[i][1], e1[1], 16);
      q = mul_round(w3[i][0], e2[0], 16) + mul_round(w3[i][1], e2[1], 16);
      rhs[i] = sat_word(ft - p - q);
    end
    det = widen(w1[0][0]) * widen(w1[1][1]) - widen(w1[0][1]) * widen(w1[1][0]);
    r.singular = (det == 0);
    if (det == 0) begin
      xc = ref_hist[0];
    end else begin
      nx = widen(w1[1][1]) * widen(rhs[0]) - widen(w1[0][1]) * widen(rhs[1]);
      ny = widen(w1[0][0]) * widen(rhs[1]) - widen(w1[1][0]) * widen(rhs[0]);
      xc[0] = sat_word(ref_hist[0][0] - quot_q16(nx, det));
      xc[1] = sat_word(ref_hist[0][1] - quot_q16(ny, det));
    end
    for (int i = 2; i > 0; i--) cmd_hist[i] = cmd_hist[i-1];
    cmd_hist[0] = xc;
    r.cmd_pos_x = xc[0][31:0];
    r.cmd_pos_y = xc[1][31:0];
    return r;
  endfunction

  // signed value in [-lim, lim]
  function automatic logic [31:0] spread(int unsigned lim);
    return 32'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  // field value: full range, a corner, or a plausible magnitude
  function automatic logic [31:0] pick_field(int unsigned lim);
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 4))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'hFFFF_FFFF;
          3: return 32'd1;
          default: return 32'd0;
        endcase
      end
      default: return spread(lim);
    endcase
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    w.stiff_11 = pick_field(200000);
    w.stiff_12 = pick_field(50000);
    w.stiff_21 = pick_field(50000);
    w.stiff_22 = pick_field(200000);
    w.ref_pos_x = pick_field(1 << 20);
    w.ref_pos_y = pick_field(1 << 20);
    w.meas_force_x = pick_field(1 << 28);
    w.meas_force_y = pick_field(1 << 28);
    return w;
  endfunction

  function automatic in_word_t fill_word(logic [31:0] stiff, logic [31:0] pos,
                                         logic [31:0] force_v);
    in_word_t w;
    w.stiff_11 = stiff;
    w.stiff_12 = stiff;
    w.stiff_21 = stiff;
    w.stiff_22 = stiff;
    w.ref_pos_x = pos;
    w.ref_pos_y = ~pos;
    w.meas_force_x = force_v;
    w.meas_force_y = ~force_v;
    return w;
  endfunction

  // send one word, with an optional idle gap before it
  task automatic send_word(in_word_t w);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 18)) begin
        @(negedge clk);
        in_if.valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_if.valid <= 1'b1;
    in_if.word <= w;
    do @(posedge clk); while (!in_if.ready);
    cmd_expected_q.push_back(impedance_step(w));
  endtask

  // wait until every expected word has arrived and the block has gone quiet
  task automatic drain();
    @(negedge clk);
    in_if.valid <= 1'b0;
    wait (cmd_expected_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MASS_11: mass_q[0][0] = longint'(signed'(data));
      CFG_MASS_12: mass_q[0][1] = longint'(signed'(data));
      CFG_MASS_21: mass_q[1][0] = longint'(signed'(data));
      CFG_MASS_22: mass_q[1][1] = longint'(signed'(data));
      CFG_DAMP_11: damp_q[0][0] = longint'(signed'(data));
      CFG_DAMP_12: damp_q[0][1] = longint'(signed'(data));
      CFG_DAMP_21: damp_q[1][0] = longint'(signed'(data));
      default:     damp_q[1][1] = longint'(signed'(data));
    endcase
  endtask

  task automatic write_all(logic [31:0] m11, logic [31:0] m12, logic [31:0] m21,
                           logic [31:0] m22, logic [31:0] d11, logic [31:0] d12,
                           logic [31:0] d21, logic [31:0] d22);
    write_reg(CFG_MASS_11, m11);
    write_reg(CFG_MASS_12, m12);
    write_reg(CFG_MASS_21, m21);
    write_reg(CFG_MASS_22, m22);
    write_reg(CFG_DAMP_11, d11);
    write_reg(CFG_DAMP_12, d12);
    write_reg(CFG_DAMP_21, d21);
    write_reg(CFG_DAMP_22, d22);
  endtask

  // reset settings: zeros, corners and small values
  task automatic test_default_settings();
    send_word(fill_word(32'd0, 32'd0, 32'd0));
    send_word(fill_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_word(fill_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_word(fill_word(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF));
    send_word(fill_word(32'd1000, 32'h0001_0000, 32'h0100_0000));
    send_word(fill_word(32'd0, 32'd0, 32'd0));
    send_word(fill_word(32'd500000, 32'hFFFF_0000, 32'h7FFF_FFFF));
    drain();
  endtask

  // zero and rank-one w1 hold the output at the reference
  task automatic test_singular_w1();
    write_all(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    send_word(fill_word(32'd0, 32'h0002_0000, 32'h0010_0000));
    send_word(fill_word(32'd0, 32'h8000_0000, 32'h8000_0000));
    send_word(fill_word(32'd3000, 32'h0000_1234, 32'h0100_0000));
    drain();
    write_all(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
              32'd0, 32'd0, 32'd0, 32'd0);
    send_word(fill_word(32'd0, 32'h0003_0000, 32'h0200_0000));
    send_word(fill_word(32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_word(fill_word(32'd70000, 32'h0000_8000, 32'hF000_0000));
    drain();
  endtask

  // saturated settings drive sums and quotients to their limits
  task automatic test_extreme_settings();
    write_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_word(fill_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
    send_word(fill_word(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
    send_word(fill_word(32'd1, 32'd0, 32'hFFFF_FFFF));
    drain();
    write_all(32'd1, 32'd0, 32'd0, 32'd1, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h7FFF_FFFF);
    send_word(fill_word(32'd0, 32'h0010_0000, 32'h7FFF_FFFF));
    send_word(fill_word(32'hFFFF_FFFF, 32'hFFF0_0000, 32'h8000_0000));
    send_word(fill_word(32'd12345, 32'h0000_0001, 32'h0000_FFFF));
    drain();
  endtask

  // random words under several random settings
  task automatic test_random_traffic();
    for (int phase = 0; phase < 5; phase++) begin
      write_all(pick_field(1 << 18), pick_field(1 << 15), pick_field(1 << 15),
                pick_field(1 << 18), pick_field(1 << 24), pick_field(1 << 20),
                pick_field(1 << 20), pick_field(1 << 24));
      idle_en = (phase < 4);
      for (int n = 0; n < 130; n++) begin
        // hold off once until the pipeline is empty
        if (phase == 1 && n == 65) begin
          @(negedge clk);
          in_if.valid <= 1'b0;
          wait (cmd_expected_q.size() == 0);
        end
        send_word(random_word());
      end
      drain();
    end
  endtask

  // output ready: random stalls while idling is on
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_en && $urandom_range(0, 2) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 18) - 1) @(negedge clk);
      end else begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 30) - 1) @(negedge clk);
      end
    end
  end

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $realtime, name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // compare each accepted word with the oldest expectation
  initial begin
    out_word_t exp_w;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        if (cmd_expected_q.size() == 0) begin
          $display("%0t: unexpected word: expected none, actual %h", $realtime, out_if.word);
          err_cnt++;
        end else begin
          exp_w = cmd_expected_q.pop_front();
          check_field("cmd_pos_x", exp_w.cmd_pos_x, out_if.word.cmd_pos_x);
          check_field("cmd_pos_y", exp_w.cmd_pos_y, out_if.word.cmd_pos_y);
          check_field("singular", 32'(exp_w.singular), 32'(out_if.word.singular));
        end
      end
    end
  end

  initial begin
    err_cnt = 0;
    idle_en = 1'b1;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_MASS_11;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.word = '0;
    clear_filter();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_default_settings();
    test_singular_w1();
    test_extreme_settings();
    test_random_traffic();
    if (err_cnt == 0 && cmd_expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
